// ----- hw/rtl/cgod_pkg.sv -----
// Shared types, constants and helpers for the cost grid occupancy/density core.
// Holds the beat structs, config register indexes and the divider step function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cgod_pkg;

    // grid and field geometry
    localparam int GRID_CELLS = 65536;
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int IDX_W      = 16;
    localparam int COST_W     = 8;
    localparam int DENS_W     = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int OCC_W      = 8;
    localparam int PCT_W      = 7;

    // occupancy divider geometry: quotient below 101 fits 7 bits
    localparam int QUO_W      = 7;
    localparam int DEN_W      = COST_W + 1;
    localparam int REM_W      = 16;

    // pipeline: stage 1 holds the memory read, stages 2..8 run the divider,
    // stage 9 is the output register
    localparam int DIV_FIRST  = 2;
    localparam int PIPE_LAST  = DIV_FIRST + QUO_W;

    // arithmetic constants
    localparam logic [COST_W-1:0]  PCT_SCALE2   = COST_W'(200);
    localparam logic [COST_W-1:0]  CLAMP_MULT   = COST_W'(202);
    localparam logic [OCC_W-1:0]   OCC_UNKNOWN_CODE = '1;
    localparam logic [OCC_W-1:0]   OCC_FULL_PCT = OCC_W'(100);
    localparam int                 DPCT_M_W     = 23;
    localparam logic [DPCT_M_W-1:0] DPCT_SCALE  = DPCT_M_W'(100);
    localparam logic [DPCT_M_W-1:0] DPCT_HALF   = DPCT_M_W'(32767);
    localparam logic [DENS_W:0]    DPCT_DIV     = (DENS_W+1)'(65535);

    // config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRACK_ENABLE   = 3'd0,
        CFG_DECAY          = 3'd1,
        CFG_UNKNOWN_COST   = 3'd2,
        CFG_INSCRIBED_COST = 3'd3,
        CFG_LETHAL_COST    = 3'd4,
        CFG_MAX_FREE_COST  = 3'd5
    } cfg_idx_t;

    // how the occupancy of a beat is formed
    typedef enum logic [1:0] {
        OCC_UNKNOWN,
        OCC_FULL,
        OCC_DIV
    } occ_sel_t;

    // input beat as held in stage 1
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [COST_W-1:0] cost;
        logic              first;
        logic              track;
    } in_beat_t;

    // beat carried through the divider stages
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              track;
        occ_sel_t          sel;
        logic [REM_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic [QUO_W-1:0]  quo;
        logic [DENS_W-1:0] nd;
        logic [PCT_W-1:0]  dpct;
    } pipe_beat_t;

    // one restoring division step for quotient bit bitpos
    function automatic pipe_beat_t div_step(input pipe_beat_t b, input int unsigned bitpos);
        pipe_beat_t       r;
        logic [REM_W-1:0] sub;
        r   = b;
        sub = REM_W'(b.den) << bitpos;
        if (b.sel == OCC_DIV && b.rem >= sub) begin
            r.rem         = b.rem - sub;
            r.quo[bitpos] = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cost_grid_occupancy_density_core.sv -----
// Throughput: one beat per cycle unless m_ready stalls. The density memory is
// read on accept, written back from stage 1, and the last write is forwarded.
// The occupancy divider runs one quotient bit per stage over 7 stages.
// Reset: synchronous active-low; clears pipeline valids, forwarding and config
// registers. Density memory has no reset and is undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module cost_grid_occupancy_density_core (
    input  wire                              aclk,
    input  wire                              aresetn,
    // config write port
    input  wire                              cfg_wr_en,
    input  wire  [cgod_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [cgod_pkg::CFG_W-1:0]       cfg_wdata,
    // input channel
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [cgod_pkg::IDX_W-1:0]       s_cell_index,
    input  wire  [cgod_pkg::COST_W-1:0]      s_cost,
    input  wire                              s_first_pass,
    // result channel
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [cgod_pkg::IDX_W-1:0]       m_out_index,
    output logic signed [cgod_pkg::OCC_W-1:0] m_occupancy,
    output logic [cgod_pkg::PCT_W-1:0]       m_density_percent,
    output logic                             m_density_valid
);

    localparam int DW = cgod_pkg::DENS_W;

    // config registers
    logic                          track_enable_reg;
    logic [DW-1:0]                 decay_reg;
    logic [cgod_pkg::COST_W-1:0]   unknown_cost_reg;
    logic [cgod_pkg::COST_W-1:0]   inscribed_cost_reg;
    logic [cgod_pkg::COST_W-1:0]   lethal_cost_reg;
    logic [cgod_pkg::COST_W-1:0]   max_free_cost_reg;

    // pipeline state
    logic [1:cgod_pkg::PIPE_LAST]  v_reg;
    logic [1:cgod_pkg::PIPE_LAST]  rdy;
    cgod_pkg::in_beat_t            s1_reg;
    cgod_pkg::pipe_beat_t          st_reg  [cgod_pkg::DIV_FIRST:cgod_pkg::PIPE_LAST];
    cgod_pkg::pipe_beat_t          st_next [cgod_pkg::DIV_FIRST:cgod_pkg::PIPE_LAST];

    // density memory and forwarding
    logic [DW-1:0]                 dens_mem [cgod_pkg::GRID_CELLS];
    logic [DW-1:0]                 rd_data_reg;
    logic                          fwd_vld_reg;
    logic [cgod_pkg::ADDR_W-1:0]   fwd_addr_reg;
    logic [DW-1:0]                 fwd_data_reg;
    logic                          wr_en;
    logic [cgod_pkg::ADDR_W-1:0]   s1_addr;
    logic                          s_accept;

    // stage 1 arithmetic
    logic [DW-1:0]                 prev;
    logic [2*DW-1:0]               prod;
    logic [DW:0]                   wgt;
    logic [2*DW:0]                 term;
    logic [2*DW+1:0]               sum;
    logic [DW-1:0]                 nd;
    logic [cgod_pkg::COST_W-1:0]   div;
    logic [cgod_pkg::REM_W-1:0]    numer;
    logic [cgod_pkg::REM_W-1:0]    clamp_thr;

    // density percent arithmetic
    logic [cgod_pkg::DPCT_M_W-1:0] dm;
    logic [cgod_pkg::PCT_W-1:0]    dq0;
    logic [DW:0]                   drem;

    assign s_accept = s_valid && s_ready;
    assign s1_addr  = s1_reg.idx[cgod_pkg::ADDR_W-1:0];
    assign wr_en    = v_reg[1] && rdy[2] && s1_reg.track;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_enable_reg   <= 1'b0;
            decay_reg          <= '0;
            unknown_cost_reg   <= cgod_pkg::COST_W'(255);
            inscribed_cost_reg <= cgod_pkg::COST_W'(253);
            lethal_cost_reg    <= cgod_pkg::COST_W'(254);
            max_free_cost_reg  <= cgod_pkg::COST_W'(252);
        end else if (cfg_wr_en) begin
            unique case (cgod_pkg::cfg_idx_t'(cfg_index))
                cgod_pkg::CFG_TRACK_ENABLE:   track_enable_reg   <= cfg_wdata[0];
                cgod_pkg::CFG_DECAY:          decay_reg          <= cfg_wdata[DW-1:0];
                cgod_pkg::CFG_UNKNOWN_COST:   unknown_cost_reg   <= cfg_wdata[cgod_pkg::COST_W-1:0];
                cgod_pkg::CFG_INSCRIBED_COST: inscribed_cost_reg <= cfg_wdata[cgod_pkg::COST_W-1:0];
                cgod_pkg::CFG_LETHAL_COST:    lethal_cost_reg    <= cfg_wdata[cgod_pkg::COST_W-1:0];
                cgod_pkg::CFG_MAX_FREE_COST:  max_free_cost_reg  <= cfg_wdata[cgod_pkg::COST_W-1:0];
                default: ;
            endcase
        end
    end

    // ready chain, bubbles collapse toward the output
    always_comb begin
        rdy[cgod_pkg::PIPE_LAST] = !v_reg[cgod_pkg::PIPE_LAST] || m_ready;
        for (int k = cgod_pkg::PIPE_LAST - 1; k >= 1; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign s_ready = rdy[1];

    // density memory: read on accept, write back from stage 1
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= dens_mem[s_cell_index[cgod_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            dens_mem[s1_addr] <= nd;
        end
    end

    // last write, forwarded to a read that missed it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_vld_reg <= 1'b0;
        end else if (wr_en) begin
            fwd_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= nd;
        end
    end

    // stage 1: density update and occupancy classification
    always_comb begin
        if (s1_reg.first) begin
            prev = '0;
        end else if (fwd_vld_reg && fwd_addr_reg == s1_addr) begin
            prev = fwd_data_reg;
        end else begin
            prev = rd_data_reg;
        end
        prod = (2*DW)'(decay_reg) * (2*DW)'(prev);
        wgt  = {1'b1, {DW{1'b0}}} - {1'b0, decay_reg};
        // (65536 - decay) * 65535 for a lethal cell
        if (s1_reg.cost == lethal_cost_reg) begin
            term = {wgt, {DW{1'b0}}} - (2*DW+1)'(wgt);
        end else begin
            term = '0;
        end
        sum = (2*DW+2)'(prod) + (2*DW+2)'(term) + (2*DW+2)'(1 << (DW - 1));
        if (sum[2*DW+1:2*DW] != 2'b00) begin
            nd = '1;
        end else begin
            nd = sum[2*DW-1:DW];
        end

        div       = (max_free_cost_reg == '0) ? cgod_pkg::COST_W'(1) : max_free_cost_reg;
        numer     = cgod_pkg::REM_W'(s1_reg.cost) * cgod_pkg::REM_W'(cgod_pkg::PCT_SCALE2)
                    + cgod_pkg::REM_W'(div);
        clamp_thr = cgod_pkg::REM_W'(div) * cgod_pkg::REM_W'(cgod_pkg::CLAMP_MULT);

        st_next[cgod_pkg::DIV_FIRST].idx   = s1_reg.idx;
        st_next[cgod_pkg::DIV_FIRST].track = s1_reg.track;
        st_next[cgod_pkg::DIV_FIRST].rem   = numer;
        st_next[cgod_pkg::DIV_FIRST].den   = {div, 1'b0};
        st_next[cgod_pkg::DIV_FIRST].quo   = '0;
        st_next[cgod_pkg::DIV_FIRST].nd    = s1_reg.track ? nd : '0;
        st_next[cgod_pkg::DIV_FIRST].dpct  = '0;
        if (s1_reg.cost == unknown_cost_reg) begin
            st_next[cgod_pkg::DIV_FIRST].sel = cgod_pkg::OCC_UNKNOWN;
        end else if (s1_reg.cost >= inscribed_cost_reg || numer >= clamp_thr) begin
            st_next[cgod_pkg::DIV_FIRST].sel = cgod_pkg::OCC_FULL;
        end else begin
            st_next[cgod_pkg::DIV_FIRST].sel = cgod_pkg::OCC_DIV;
        end

        // divider stages, one quotient bit each
        for (int k = cgod_pkg::DIV_FIRST; k < cgod_pkg::PIPE_LAST; k++) begin
            st_next[k+1] = cgod_pkg::div_step(st_reg[k],
                unsigned'(cgod_pkg::QUO_W + cgod_pkg::DIV_FIRST - 1 - k));
            if (k == cgod_pkg::DIV_FIRST) begin
                st_next[k+1].dpct = (drem >= cgod_pkg::DPCT_DIV) ? dq0 + 1'b1 : dq0;
            end
        end
    end

    // density percent: round(100*nd/65535) by reciprocal and one correction
    always_comb begin
        dm   = cgod_pkg::DPCT_M_W'(st_reg[cgod_pkg::DIV_FIRST].nd) * cgod_pkg::DPCT_SCALE
               + cgod_pkg::DPCT_HALF;
        dq0  = dm[cgod_pkg::DPCT_M_W-1:DW];
        drem = (DW+1)'(dm[DW-1:0]) + (DW+1)'(dq0);
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[1]) begin
                v_reg[1] <= s_valid;
            end
            for (int k = 2; k <= cgod_pkg::PIPE_LAST; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_reg.idx   <= s_cell_index;
            s1_reg.cost  <= s_cost;
            s1_reg.first <= s_first_pass;
            s1_reg.track <= track_enable_reg;
        end
        for (int k = cgod_pkg::DIV_FIRST; k <= cgod_pkg::PIPE_LAST; k++) begin
            if (rdy[k] && v_reg[k-1]) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // result beat
    always_comb begin
        m_valid           = v_reg[cgod_pkg::PIPE_LAST];
        m_out_index       = st_reg[cgod_pkg::PIPE_LAST].idx;
        m_density_valid   = st_reg[cgod_pkg::PIPE_LAST].track;
        m_density_percent = st_reg[cgod_pkg::PIPE_LAST].dpct;
        unique case (st_reg[cgod_pkg::PIPE_LAST].sel)
            cgod_pkg::OCC_UNKNOWN: m_occupancy = $signed(cgod_pkg::OCC_UNKNOWN_CODE);
            cgod_pkg::OCC_FULL:    m_occupancy = $signed(cgod_pkg::OCC_FULL_PCT);
            default:               m_occupancy = $signed({1'b0, st_reg[cgod_pkg::PIPE_LAST].quo});
        endcase
    end

endmodule

`default_nettype wire

// ----- tb/cost_grid_occupancy_density_core_tb.sv -----
// Self-checking testbench for cost_grid_occupancy_density_core: occupancy mapping and
// per-cell lethal density tracking, checked beat by beat against an in-bench predictor.
// Depends on cgod_pkg and the core RTL only.
`timescale 1ns / 1ps

module cost_grid_occupancy_density_core_tb;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 10;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 170;

    // one expected result beat
    typedef struct {
        logic [cgod_pkg::IDX_W-1:0]  idx;
        logic [cgod_pkg::OCC_W-1:0]  occ;
        logic [cgod_pkg::PCT_W-1:0]  dpct;
        logic                        dvalid;
    } occ_result_t;

    // predictor of occupancy and density plus the queue of expected beats
    class occupancy_scoreboard;
        logic                        trk;
        logic [15:0]                 dcy;
        logic [7:0]                  unk;
        logic [7:0]                  insc;
        logic [7:0]                  leth;
        logic [7:0]                  maxf;
        logic [cgod_pkg::DENS_W-1:0] dens [cgod_pkg::GRID_CELLS];
        bit                          seen [cgod_pkg::GRID_CELLS];
        occ_result_t                 awaited_q [$];
        int                          errors;
        int                          reported;
        int                          checked;

        function new();
            trk      = 1'b0;
            dcy      = '0;
            unk      = 8'd255;
            insc     = 8'd253;
            leth     = 8'd254;
            maxf     = 8'd252;
            errors   = 0;
            reported = 0;
            checked  = 0;
        endfunction

        function void set_reg(cgod_pkg::cfg_idx_t ri, logic [cgod_pkg::CFG_W-1:0] v);
            case (ri)
                cgod_pkg::CFG_TRACK_ENABLE:   trk  = v[0];
                cgod_pkg::CFG_DECAY:          dcy  = v[15:0];
                cgod_pkg::CFG_UNKNOWN_COST:   unk  = v[7:0];
                cgod_pkg::CFG_INSCRIBED_COST: insc = v[7:0];
                cgod_pkg::CFG_LETHAL_COST:    leth = v[7:0];
                cgod_pkg::CFG_MAX_FREE_COST:  maxf = v[7:0];
                default: ;
            endcase
        endfunction

        // a stored density may only be read once it has been written
        function bit must_start_fresh(logic [cgod_pkg::IDX_W-1:0] i);
            return trk && !seen[i];
        endfunction

        function logic [cgod_pkg::OCC_W-1:0] occ_of(logic [cgod_pkg::COST_W-1:0] c);
            int unsigned dv;
            int unsigned pct;
            if (c == unk) return 8'hFF;
            if (c >= insc) return 8'd100;
            dv  = (maxf == 0) ? 1 : int'(maxf);
            pct = (200 * int'(c) + dv) / (2 * dv);
            if (pct > 100) pct = 100;
            return pct[7:0];
        endfunction

        function void note_beat(logic [cgod_pkg::IDX_W-1:0] i,
                                logic [cgod_pkg::COST_W-1:0] c, logic fp);
            occ_result_t       r;
            longint unsigned   prev;
            longint unsigned   tgt;
            longint unsigned   nd;
            longint unsigned   pc;
            r.idx    = i;
            r.occ    = occ_of(c);
            r.dpct   = '0;
            r.dvalid = 1'b0;
            // exponential blend toward full density on lethal hits, toward zero otherwise
            if (trk) begin
                prev = fp ? 0 : longint'(dens[i]);
                tgt  = (c == leth) ? 65535 : 0;
                nd   = (longint'(dcy) * prev + (65536 - longint'(dcy)) * tgt + 32768) >> 16;
                if (nd > 65535) nd = 65535;
                dens[i] = nd[15:0];
                seen[i] = 1'b1;
                pc = (200 * nd + 65535) / 131070;
                if (pc > 100) pc = 100;
                r.dpct   = pc[6:0];
                r.dvalid = 1'b1;
            end
            awaited_q.push_back(r);
        endfunction

        function void check_beat(logic [cgod_pkg::IDX_W-1:0] i, logic [cgod_pkg::OCC_W-1:0] o,
                                 logic [cgod_pkg::PCT_W-1:0] p, logic dv);
            occ_result_t e;
            if (awaited_q.size() == 0) begin
                errors++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("unexpected result beat: idx %0d occ %0d", i, $signed(o));
                end
                return;
            end
            e = awaited_q.pop_front();
            checked++;
            if (i !== e.idx || o !== e.occ || p !== e.dpct || dv !== e.dvalid) begin
                errors++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("mismatch: idx %0d/%0d occ %0d/%0d dpct %0d/%0d dvalid %0b/%0b",
                             e.idx, i, $signed(e.occ), $signed(o), e.dpct, p, e.dvalid, dv);
                end
            end
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction
    endclass

    logic                              aclk    = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              cfg_wr_en;
    logic [cgod_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [cgod_pkg::CFG_W-1:0]        cfg_wdata;
    logic                              s_valid;
    logic                              s_ready;
    logic [cgod_pkg::IDX_W-1:0]        s_cell_index;
    logic [cgod_pkg::COST_W-1:0]       s_cost;
    logic                              s_first_pass;
    logic                              m_valid;
    logic                              m_ready;
    logic [cgod_pkg::IDX_W-1:0]        m_out_index;
    logic signed [cgod_pkg::OCC_W-1:0] m_occupancy;
    logic [cgod_pkg::PCT_W-1:0]        m_density_percent;
    logic                              m_density_valid;

    occupancy_scoreboard sb;
    bit send_eager;
    bit sink_eager;
    int beats_sent;
    int settings_used;

    cost_grid_occupancy_density_core DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cell_index      (s_cell_index),
        .s_cost            (s_cost),
        .s_first_pass      (s_first_pass),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_index       (m_out_index),
        .m_occupancy       (m_occupancy),
        .m_density_percent (m_density_percent),
        .m_density_valid   (m_density_valid)
    );

    // clock
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // run limit
    initial begin
        #20000000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("TEST FAILED");
        $finish;
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_beat(m_out_index, m_occupancy, m_density_percent, m_density_valid);
    end

    // result sink: random stall before each beat unless running eager
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = sink_eager ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // register write while the core is idle
    task automatic cfg_write(cgod_pkg::cfg_idx_t ri, logic [cgod_pkg::CFG_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = ri;
        cfg_wdata = v;
        @(posedge aclk);
        sb.set_reg(ri, v);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // wait for every expected result, then let the pipeline settle
    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_all(logic trk, logic [15:0] dcy, logic [7:0] unk, logic [7:0] insc,
                             logic [7:0] leth, logic [7:0] maxf);
        wait_drained();
        cfg_write(cgod_pkg::CFG_TRACK_ENABLE, cgod_pkg::CFG_W'(trk));
        cfg_write(cgod_pkg::CFG_DECAY, dcy);
        cfg_write(cgod_pkg::CFG_UNKNOWN_COST, cgod_pkg::CFG_W'(unk));
        cfg_write(cgod_pkg::CFG_INSCRIBED_COST, cgod_pkg::CFG_W'(insc));
        cfg_write(cgod_pkg::CFG_LETHAL_COST, cgod_pkg::CFG_W'(leth));
        cfg_write(cgod_pkg::CFG_MAX_FREE_COST, cgod_pkg::CFG_W'(maxf));
        settings_used++;
    endtask

    // one input beat; caller sits just after a falling edge
    task automatic send_cell(logic [cgod_pkg::IDX_W-1:0] i, logic [cgod_pkg::COST_W-1:0] c,
                             logic fp);
        int gap;
        gap = send_eager ? 0 : $urandom_range(0, 10);
        if (sb.must_start_fresh(i)) fp = 1'b1;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_cell_index = i;
        s_cost       = c;
        s_first_pass = fp;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(i, c, fp);
        beats_sent++;
        @(negedge aclk);
        // a following beat raises valid again in this same step
        s_valid = 1'b0;
    endtask

    // random register setting, extremes weighted in
    task automatic random_setting(int ph);
        logic [15:0] dcy;
        logic [7:0]  unk;
        logic [7:0]  insc;
        logic [7:0]  leth;
        logic [7:0]  maxf;
        case ($urandom_range(0, 3))
            0:       dcy = 16'h0000;
            1:       dcy = 16'hFFFF;
            2:       dcy = 16'h8000;
            default: dcy = 16'($urandom);
        endcase
        unk = ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom);
        case ($urandom_range(0, 3))
            0:       insc = 8'd253;
            1:       insc = 8'd0;
            2:       insc = 8'd255;
            default: insc = 8'($urandom);
        endcase
        leth = ($urandom_range(0, 1) == 0) ? 8'd254 : 8'($urandom);
        case ($urandom_range(0, 3))
            0:       maxf = 8'd1;
            1:       maxf = 8'd255;
            2:       maxf = 8'd0;
            default: maxf = 8'($urandom);
        endcase
        write_all((ph % 4) != 3, dcy, unk, insc, leth, maxf);
    endtask

    // random beats: mostly a few hot cells so densities build up
    task automatic random_phase();
        logic [cgod_pkg::IDX_W-1:0]  hot [8];
        logic [cgod_pkg::IDX_W-1:0]  i;
        logic [cgod_pkg::COST_W-1:0] c;
        foreach (hot[k]) hot[k] = 16'($urandom);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_eager = (n >= 40 && n < 80) || (n >= 120 && n < 140);
            sink_eager = (n >= 40 && n < 80);
            if (n == 100) wait_drained();
            i = ($urandom_range(0, 99) < 70) ? hot[$urandom_range(0, 7)] : 16'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: c = sb.leth;
                4:          c = sb.unk;
                5:          c = sb.insc;
                6:          c = sb.insc - 8'd1;
                default:    c = 8'($urandom);
            endcase
            send_cell(i, c, $urandom_range(0, 9) == 0);
        end
        send_eager = 1'b0;
        sink_eager = 1'b0;
    endtask

    // main sequence
    initial begin
        int fails;
        sb            = new();
        send_eager    = 1'b0;
        sink_eager    = 1'b0;
        beats_sent    = 0;
        settings_used = 1;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_cell_index  = '0;
        s_cost        = '0;
        s_first_pass  = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset settings, tracking off; unknown code wins over inscribed
        send_cell(16'd0, 8'd0, 1'b0);
        send_cell(16'hFFFF, 8'd255, 1'b1);
        send_cell(16'd1, 8'd253, 1'b0);
        send_cell(16'd2, 8'd254, 1'b0);
        send_cell(16'd3, 8'd252, 1'b0);
        send_cell(16'd4, 8'd126, 1'b1);
        send_cell(16'd5, 8'd1, 1'b0);

        // tracking on, decay at maximum, repeated index in consecutive beats
        write_all(1'b1, 16'hFFFF, 8'd0, 8'd255, 8'd255, 8'd255);
        send_cell(16'd0, 8'd255, 1'b1);
        send_cell(16'd0, 8'd255, 1'b0);
        send_cell(16'd0, 8'd0, 1'b0);
        send_cell(16'hFFFF, 8'd254, 1'b1);
        send_cell(16'hFFFF, 8'd128, 1'b0);

        // zero divisor, decay zero, lethal code zero
        write_all(1'b1, 16'h0000, 8'd255, 8'd255, 8'd0, 8'd0);
        send_cell(16'd7, 8'd0, 1'b1);
        send_cell(16'd7, 8'd1, 1'b0);
        send_cell(16'd7, 8'd254, 1'b0);
        send_cell(16'd7, 8'd255, 1'b0);
        send_cell(16'd7, 8'd0, 1'b0);

        // inscribed at zero, unknown equal to lethal, half decay
        write_all(1'b1, 16'h8000, 8'd128, 8'd0, 8'd128, 8'd1);
        send_cell(16'd9, 8'd128, 1'b1);
        send_cell(16'd9, 8'd0, 1'b0);
        send_cell(16'd9, 8'd128, 1'b0);
        send_cell(16'd9, 8'd77, 1'b0);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            random_setting(ph);
            random_phase();
        end

        s_valid = 1'b0;
        wait_drained();
        fails = sb.errors;
        if (sb.pending() != 0) begin
            $display("%0d expected results never arrived", sb.pending());
            fails += sb.pending();
        end
        $display("sent %0d cell beats under %0d register settings, %0d results checked",
                 beats_sent, settings_used, sb.checked);
        $display("failures: %0d", fails);
        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
